@@ sv/assert_macros.svh @@
// Assertion macros used by the decoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPLIES(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);

// Condition that must never hold outside reset.
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error(msg);

`endif

@@ sv/ipd_pkg.sv @@
// Types, pattern table and rank tables for the instruction pattern decoder.
package ipd_pkg;

    localparam int TABLE_SIZE    = 131;
    localparam int PATTERN_COUNT = 131;
    localparam int ACTIVE        = (PATTERN_COUNT < TABLE_SIZE) ? PATTERN_COUNT : TABLE_SIZE;
    localparam int GROUP_SIZE    = 16;
    localparam int POS_W         = $clog2(GROUP_SIZE);
    localparam int GROUPS        = (ACTIVE + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int GRP_W         = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int SLOTS         = GROUPS * GROUP_SIZE;
    localparam int RANK_W        = GRP_W + POS_W;
    localparam int IDX_W         = 8;

    typedef struct packed {
        logic [15:0] first_word;
        logic [15:0] second_word;
    } t_in;

    typedef struct packed {
        logic        matched;
        logic [7:0]  opcode_index;
        logic [1:0]  length_words;
        logic [4:0]  dest_reg;
        logic [4:0]  src_reg;
        logic [7:0]  immediate;
        logic [21:0] target;
        logic [5:0]  io_addr;
        logic [2:0]  bit_number;
        logic [2:0]  flag_number;
        logic [5:0]  displacement;
    } t_out;

    // Operand layouts: where each letter sits in the instruction word(s).
    typedef enum logic [4:0] {
        LY_NONE, LY_RD, LY_KDI, LY_ADIW, LY_D5, LY_S, LY_DB, LY_KS, LY_K7, LY_K22,
        LY_AB, LY_MUL3, LY_IN, LY_DQ, LY_LDS, LY_D4R4, LY_OUT, LY_K12, LY_SER,
        LY_RB, LY_R5, LY_RQ
    } t_layout;

    // Per-group hit summary between match stage and rank select.
    typedef struct packed {
        logic [GROUPS-1:0]            hit;
        logic [GROUPS-1:0][POS_W-1:0] pos;
    } t_grp;

    typedef logic [IDX_W-1:0] t_order [SLOTS];
    typedef t_layout          t_lay_arr [SLOTS];

    // Fixed bits of the first word (second words are all operand bits).
    localparam logic [15:0] PAT_VALUE [TABLE_SIZE] = '{
        16'h1C00, 16'h0C00, 16'h9600, 16'h2000, 16'h7000, 16'h9405, 16'h9488, 16'hF800,
        16'hF400, 16'hF000, 16'hF400, 16'hF000, 16'h9598, 16'hF001, 16'hF404, 16'hF405,
        16'hF005, 16'hF407, 16'hF007, 16'hF000, 16'hF004, 16'hF002, 16'hF401, 16'hF402,
        16'hF400, 16'hF406, 16'hF006, 16'hF403, 16'hF003, 16'h9408, 16'hFA00, 16'h940E,
        16'h9800, 16'h9488, 16'h94D8, 16'h94F8, 16'h94A8, 16'h94C8, 16'h94E8, 16'h94B8,
        16'h9498, 16'h9400, 16'h1400, 16'h0400, 16'h3000, 16'h1000, 16'h940A, 16'h9519,
        16'h9419, 16'h95D8, 16'h9006, 16'h9007, 16'h2400, 16'h0308, 16'h0380, 16'h0388,
        16'h9509, 16'h9409, 16'hB000, 16'h9403, 16'h940C, 16'h900C, 16'h900D, 16'h900E,
        16'h8008, 16'h9009, 16'h900A, 16'h8008, 16'h8000, 16'h9001, 16'h9002, 16'h8000,
        16'hE000, 16'h9000, 16'h95C8, 16'h9004, 16'h9005, 16'h9406, 16'h2C00, 16'h0100,
        16'h9C00, 16'h0200, 16'h0300, 16'h9401, 16'h0000, 16'h2800, 16'h6000, 16'hB800,
        16'h900F, 16'h920F, 16'hD000, 16'h9508, 16'h9518, 16'hC000, 16'h9407, 16'h0800,
        16'h4000, 16'h9A00, 16'h9900, 16'h9B00, 16'h9700, 16'h6000, 16'hFC00, 16'hFE00,
        16'h9408, 16'h9458, 16'h9478, 16'h9428, 16'hEF0F, 16'h9448, 16'h9468, 16'h9438,
        16'h9418, 16'h9588, 16'h95E8, 16'h920C, 16'h920D, 16'h920E, 16'h8208, 16'h9209,
        16'h920A, 16'h8208, 16'h8200, 16'h9201, 16'h9202, 16'h8200, 16'h9200, 16'h1800,
        16'h5000, 16'h9402, 16'h95A8
    };

    localparam logic [15:0] PAT_MASK [TABLE_SIZE] = '{
        16'hFC00, 16'hFC00, 16'hFF00, 16'hFC00, 16'hF000, 16'hFE0F, 16'hFF8F, 16'hFE08,
        16'hFC00, 16'hFC00, 16'hFC07, 16'hFC07, 16'hFFFF, 16'hFC07, 16'hFC07, 16'hFC07,
        16'hFC07, 16'hFC07, 16'hFC07, 16'hFC07, 16'hFC07, 16'hFC07, 16'hFC07, 16'hFC07,
        16'hFC07, 16'hFC07, 16'hFC07, 16'hFC07, 16'hFC07, 16'hFF8F, 16'hFE08, 16'hFE0E,
        16'hFF00, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
        16'hFFFF, 16'hFE0F, 16'hFC00, 16'hFC00, 16'hF000, 16'hFC00, 16'hFE0F, 16'hFFFF,
        16'hFFFF, 16'hFFFF, 16'hFE0F, 16'hFE0F, 16'hFC00, 16'hFF88, 16'hFF88, 16'hFF88,
        16'hFFFF, 16'hFFFF, 16'hF800, 16'hFE0F, 16'hFE0E, 16'hFE0F, 16'hFE0F, 16'hFE0F,
        16'hFE0F, 16'hFE0F, 16'hFE0F, 16'hD208, 16'hFE0F, 16'hFE0F, 16'hFE0F, 16'hD208,
        16'hF000, 16'hFE0F, 16'hFFFF, 16'hFE0F, 16'hFE0F, 16'hFE0F, 16'hFC00, 16'hFF00,
        16'hFC00, 16'hFF00, 16'hFF88, 16'hFE0F, 16'hFFFF, 16'hFC00, 16'hF000, 16'hF800,
        16'hFE0F, 16'hFE0F, 16'hF000, 16'hFFFF, 16'hFFFF, 16'hF000, 16'hFE0F, 16'hFC00,
        16'hF000, 16'hFF00, 16'hFF00, 16'hFF00, 16'hFF00, 16'hF000, 16'hFE08, 16'hFE08,
        16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFF0F, 16'hFFFF, 16'hFFFF, 16'hFFFF,
        16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFE0F, 16'hFE0F, 16'hFE0F, 16'hFE0F, 16'hFE0F,
        16'hFE0F, 16'hD208, 16'hFE0F, 16'hFE0F, 16'hFE0F, 16'hD208, 16'hFE0F, 16'hFC00,
        16'hF000, 16'hFE0F, 16'hFFFF
    };

    localparam t_layout PAT_LAYOUT [TABLE_SIZE] = '{
        LY_RD,   LY_RD,   LY_ADIW, LY_RD,   LY_KDI,  LY_D5,   LY_S,    LY_DB,
        LY_KS,   LY_KS,   LY_K7,   LY_K7,   LY_NONE, LY_K7,   LY_K7,   LY_K7,
        LY_K7,   LY_K7,   LY_K7,   LY_K7,   LY_K7,   LY_K7,   LY_K7,   LY_K7,
        LY_K7,   LY_K7,   LY_K7,   LY_K7,   LY_K7,   LY_S,    LY_DB,   LY_K22,
        LY_AB,   LY_NONE, LY_NONE, LY_NONE, LY_NONE, LY_NONE, LY_NONE, LY_NONE,
        LY_NONE, LY_D5,   LY_RD,   LY_RD,   LY_KDI,  LY_RD,   LY_D5,   LY_NONE,
        LY_NONE, LY_NONE, LY_D5,   LY_D5,   LY_RD,   LY_MUL3, LY_MUL3, LY_MUL3,
        LY_NONE, LY_NONE, LY_IN,   LY_D5,   LY_K22,  LY_D5,   LY_D5,   LY_D5,
        LY_D5,   LY_D5,   LY_D5,   LY_DQ,   LY_D5,   LY_D5,   LY_D5,   LY_DQ,
        LY_KDI,  LY_LDS,  LY_NONE, LY_D5,   LY_D5,   LY_D5,   LY_RD,   LY_D4R4,
        LY_RD,   LY_D4R4, LY_MUL3, LY_D5,   LY_NONE, LY_RD,   LY_KDI,  LY_OUT,
        LY_D5,   LY_D5,   LY_K12,  LY_NONE, LY_NONE, LY_K12,  LY_D5,   LY_RD,
        LY_KDI,  LY_AB,   LY_AB,   LY_AB,   LY_ADIW, LY_KDI,  LY_RB,   LY_RB,
        LY_NONE, LY_NONE, LY_NONE, LY_NONE, LY_SER,  LY_NONE, LY_NONE, LY_NONE,
        LY_NONE, LY_NONE, LY_NONE, LY_R5,   LY_R5,   LY_R5,   LY_R5,   LY_R5,
        LY_R5,   LY_RQ,   LY_R5,   LY_R5,   LY_R5,   LY_RQ,   LY_LDS,  LY_RD,
        LY_KDI,  LY_D5,   LY_NONE
    };

    function automatic int fixed_bits(input logic [15:0] mask);
        int c;
        c = 0;
        for (int b = 0; b < 16; b++) begin
            c = c + int'(mask[b]);
        end
        return c;
    endfunction

    // Slot r holds the pattern of rank r: more fixed bits first, then table order.
    function automatic t_order calc_order();
        t_order ord;
        int     r;
        int     fi;
        for (int s = 0; s < SLOTS; s++) begin
            ord[s] = '0;
        end
        for (int i = 0; i < ACTIVE; i++) begin
            r  = 0;
            fi = fixed_bits(PAT_MASK[i]);
            for (int j = 0; j < ACTIVE; j++) begin
                if (fixed_bits(PAT_MASK[j]) > fi || (fixed_bits(PAT_MASK[j]) == fi && j < i)) begin
                    r = r + 1;
                end
            end
            ord[r] = IDX_W'(i);
        end
        return ord;
    endfunction

    localparam t_order RANK_ORDER = calc_order();

    function automatic t_lay_arr calc_layout();
        t_lay_arr la;
        for (int s = 0; s < SLOTS; s++) begin
            la[s] = PAT_LAYOUT[RANK_ORDER[s]];
        end
        return la;
    endfunction

    localparam t_lay_arr RANK_LAYOUT = calc_layout();

endpackage

@@ sv/ipd_match.sv @@
// Pattern compare in rank order and per-group priority encode, two register stages.
module ipd_match import ipd_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_in  i_words,
    output logic o_valid,
    output t_in  o_words,
    output t_grp o_grp
);

    logic             r_m_valid;
    t_in              r_m_words;
    logic [SLOTS-1:0] r_match;
    logic [SLOTS-1:0] n_match;

    logic             r_g_valid;
    t_in              r_g_words;
    t_grp             r_grp;
    t_grp             n_grp;

    // Compare the first word against every active pattern, placed by rank.
    always_comb begin
        for (int s = 0; s < SLOTS; s++) begin
            if (s < ACTIVE) begin
                n_match[s] = ((i_words.first_word & PAT_MASK[RANK_ORDER[s]])
                              == PAT_VALUE[RANK_ORDER[s]]);
            end else begin
                n_match[s] = 1'b0;
            end
        end
    end

    // First hit (lowest rank) inside each group.
    always_comb begin
        for (int g = 0; g < GROUPS; g++) begin
            n_grp.hit[g] = |r_match[g*GROUP_SIZE +: GROUP_SIZE];
            n_grp.pos[g] = '0;
            for (int p = GROUP_SIZE - 1; p >= 0; p--) begin
                if (r_match[g*GROUP_SIZE + p]) begin
                    n_grp.pos[g] = POS_W'(p);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
            r_g_valid <= 1'b0;
        end else begin
            r_m_valid <= i_valid;
            r_g_valid <= r_m_valid;
        end
        r_m_words <= i_words;
        r_match   <= n_match;
        r_g_words <= r_m_words;
        r_grp     <= n_grp;
    end

    assign o_valid = r_g_valid;
    assign o_words = r_g_words;
    assign o_grp   = r_grp;

endmodule

@@ sv/instruction_pattern_decoder.sv @@
// Top level of the instruction pattern decoder: input stage, rank select, field gather.
//
// Usage
//   Input: drive i_item (first_word, second_word) and raise start. The item is
//   taken at every rising edge where start is high and busy is low. busy is
//   always low, so one item may be offered in every cycle.
//   Output: o_valid is high for exactly one cycle with the decoded item on
//   o_result; the receiver must take it in that cycle, it cannot stall.
//   Pipeline: the item passes through five register stages (input, pattern
//   compare, group encode, rank select, field gather), the last driving
//   o_result. Throughput: one item per cycle, as every stage advances each
//   cycle and busy never rises.
//   Decoding: the pattern with the most fixed bits wins, ties go to the
//   lower table index. Unused operand fields read 0. No match gives
//   matched 0, opcode_index 0, length_words 1.
//   Reset: synchronous, active low; clears all stage valid bits so no result
//   is issued for items in flight. No clearing pass, no configuration.
`include "assert_macros.svh"

module instruction_pattern_decoder import ipd_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_in  i_item,
    output logic o_valid,
    output t_out o_result
);

    // stage 1: input register
    logic              r_s1_valid;
    t_in               r_s1_words;

    // stages 2-3 live in the matcher
    logic              w_m_valid;
    t_in               w_m_words;
    t_grp              w_grp;

    // stage 4: rank of the winner
    logic              r_s4_valid;
    logic              r_s4_hit;
    logic [RANK_W-1:0] r_s4_rank;
    t_in               r_s4_words;
    logic              n_s4_hit;
    logic [RANK_W-1:0] n_s4_rank;

    // stage 5: output register
    logic              r_out_valid;
    t_out              r_out;
    t_out              n_out;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= start & ~busy;
        end
        r_s1_words <= i_item;
    end

    ipd_match u_match (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s1_valid),
        .i_words (r_s1_words),
        .o_valid (w_m_valid),
        .o_words (w_m_words),
        .o_grp   (w_grp)
    );

    // Lowest group with a hit holds the best rank.
    always_comb begin
        n_s4_hit  = |w_grp.hit;
        n_s4_rank = '0;
        for (int g = GROUPS - 1; g >= 0; g--) begin
            if (w_grp.hit[g]) begin
                n_s4_rank = {GRP_W'(g), w_grp.pos[g]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_valid <= 1'b0;
        end else begin
            r_s4_valid <= w_m_valid;
        end
        r_s4_hit   <= n_s4_hit;
        r_s4_rank  <= n_s4_rank;
        r_s4_words <= w_m_words;
    end

    // Gather operand bits by the winner's layout.
    always_comb begin
        logic [15:0] w;
        logic [15:0] w2;
        w  = r_s4_words.first_word;
        w2 = r_s4_words.second_word;
        n_out              = '0;
        n_out.length_words = 2'd1;
        if (r_s4_hit) begin
            n_out.matched      = 1'b1;
            n_out.opcode_index = RANK_ORDER[r_s4_rank];
            unique case (RANK_LAYOUT[r_s4_rank])
                LY_NONE: begin
                end
                LY_RD: begin
                    n_out.dest_reg = w[8:4];
                    n_out.src_reg  = {w[9], w[3:0]};
                end
                LY_KDI: begin
                    n_out.immediate = {w[11:8], w[3:0]};
                    n_out.dest_reg  = {1'b0, w[7:4]};
                end
                LY_ADIW: begin
                    n_out.immediate = {2'b00, w[7:6], w[3:0]};
                    n_out.dest_reg  = {3'b000, w[5:4]};
                end
                LY_D5: begin
                    n_out.dest_reg = w[8:4];
                end
                LY_S: begin
                    n_out.flag_number = w[6:4];
                end
                LY_DB: begin
                    n_out.dest_reg   = w[8:4];
                    n_out.bit_number = w[2:0];
                end
                LY_KS: begin
                    n_out.target      = {15'd0, w[9:3]};
                    n_out.flag_number = w[2:0];
                end
                LY_K7: begin
                    n_out.target = {15'd0, w[9:3]};
                end
                LY_K22: begin
                    n_out.target       = {w[8:4], w[0], w2};
                    n_out.length_words = 2'd2;
                end
                LY_AB: begin
                    n_out.io_addr    = {1'b0, w[7:3]};
                    n_out.bit_number = w[2:0];
                end
                LY_MUL3: begin
                    n_out.dest_reg = {2'b00, w[6:4]};
                    n_out.src_reg  = {2'b00, w[2:0]};
                end
                LY_IN: begin
                    n_out.io_addr  = {w[10:9], w[3:0]};
                    n_out.dest_reg = w[8:4];
                end
                LY_DQ: begin
                    n_out.displacement = {w[13], w[11:10], w[2:0]};
                    n_out.dest_reg     = w[8:4];
                end
                LY_LDS: begin
                    n_out.dest_reg     = w[8:4];
                    n_out.target       = {6'd0, w2};
                    n_out.length_words = 2'd2;
                end
                LY_D4R4: begin
                    n_out.dest_reg = {1'b0, w[7:4]};
                    n_out.src_reg  = {1'b0, w[3:0]};
                end
                LY_OUT: begin
                    n_out.io_addr = {w[10:9], w[3:0]};
                    n_out.src_reg = w[8:4];
                end
                LY_K12: begin
                    n_out.target = {10'd0, w[11:0]};
                end
                LY_SER: begin
                    n_out.dest_reg = {1'b0, w[7:4]};
                end
                LY_RB: begin
                    n_out.src_reg    = w[8:4];
                    n_out.bit_number = w[2:0];
                end
                LY_R5: begin
                    n_out.src_reg = w[8:4];
                end
                LY_RQ: begin
                    n_out.displacement = {w[13], w[11:10], w[2:0]};
                    n_out.src_reg      = w[8:4];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_s4_valid;
        end
        r_out <= n_out;
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    `ASSERT_IMPLIES(a_no_match_defaults, o_valid && !o_result.matched,
        o_result.opcode_index == 8'd0 && o_result.length_words == 2'd1,
        "unmatched item has nonzero index or length")
    `ASSERT_NEVER(a_length_range,
        o_valid && o_result.length_words != 2'd1 && o_result.length_words != 2'd2,
        "length out of range")
    `ASSERT_IMPLIES(a_result_has_item, o_valid, $past(r_s1_valid, 4),
        "result without an item in flight")

endmodule
